[rtl/tsg_pkg.sv]
package tsg_pkg;

    // command symbols (ASCII)
    localparam logic [7:0] SYM_FWD   = 8'h46;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_OPEN  = 8'h5B;
    localparam logic [7:0] SYM_CLOSE = 8'h5D;

    // configuration register indexes
    localparam logic [2:0] CFG_START_X         = 3'd0;
    localparam logic [2:0] CFG_START_Y         = 3'd1;
    localparam logic [2:0] CFG_START_HEADING_X = 3'd2;
    localparam logic [2:0] CFG_START_HEADING_Y = 3'd3;
    localparam logic [2:0] CFG_STEP_LENGTH     = 3'd4;
    localparam logic [2:0] CFG_TURN_COS        = 3'd5;
    localparam logic [2:0] CFG_TURN_SIN        = 3'd6;

    localparam logic signed [16:0] NO_SEGMENT = -17'sd1;

    localparam logic signed [31:0] RST_START_X         = 32'sd0;
    localparam logic signed [31:0] RST_START_Y         = 32'sd0;
    localparam logic signed [15:0] RST_START_HEADING_X = 16'sd0;
    localparam logic signed [15:0] RST_START_HEADING_Y = -16'sd16384;
    localparam logic [23:0]        RST_STEP_LENGTH     = 24'd65536;
    localparam logic signed [15:0] RST_TURN_COS        = 16'sd16384;
    localparam logic signed [15:0] RST_TURN_SIN        = 16'sd0;

    localparam logic signed [15:0] HEAD_MAX = 16'sh7FFF;
    localparam logic signed [15:0] HEAD_MIN = 16'sh8000;
    localparam logic signed [31:0] POS_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN  = 32'sh8000_0000;

    typedef enum logic [1:0] {
        STATUS_SEGMENT     = 2'd0,
        STATUS_STACK_FULL  = 2'd1,
        STATUS_STACK_EMPTY = 2'd2,
        STATUS_COUNT_FULL  = 2'd3
    } status_t;

    // one branch stack entry
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic signed [16:0] prev;
    } frame_t;

endpackage

[rtl/turtle_segment_generator_top.sv]
// An accepted item waits in the input register; its result then lands in the output register.
// Throughput: one item per cycle unless a held result stalls the single compute stage, which sees
// the previous item's turtle state; when stalled, in_stall rises once the input register is full.
// Reset (rst_n low, asynchronous): pen at the reset start registers, empty branch stack,
// segment count zero, no item held. Start registers reach the turtle only on reset or on an
// item with restart set; step length and turn apply from the next item on.
module turtle_segment_generator_top #(
    parameter int STACK_DEPTH  = 32,
    parameter int MAX_SEGMENTS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         symbol,
    input  logic               restart,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] seg_start_x,
    output logic signed [31:0] seg_start_y,
    output logic signed [31:0] seg_end_x,
    output logic signed [31:0] seg_end_y,
    output logic signed [16:0] parent_index,
    output logic [15:0]        segment_index,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // ------------------------------------------------------------------
    // Configuration registers: always ready, writes are registered.
    // ------------------------------------------------------------------
    logic signed [31:0] start_x_reg, start_y_reg;
    logic signed [15:0] start_hx_reg, start_hy_reg;
    logic [23:0]        step_len_reg;
    logic signed [15:0] turn_cos_reg, turn_sin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= tsg_pkg::RST_START_X;
            start_y_reg  <= tsg_pkg::RST_START_Y;
            start_hx_reg <= tsg_pkg::RST_START_HEADING_X;
            start_hy_reg <= tsg_pkg::RST_START_HEADING_Y;
            step_len_reg <= tsg_pkg::RST_STEP_LENGTH;
            turn_cos_reg <= tsg_pkg::RST_TURN_COS;
            turn_sin_reg <= tsg_pkg::RST_TURN_SIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsg_pkg::CFG_START_X:         start_x_reg  <= cfg_data;
                tsg_pkg::CFG_START_Y:         start_y_reg  <= cfg_data;
                tsg_pkg::CFG_START_HEADING_X: start_hx_reg <= cfg_data[15:0];
                tsg_pkg::CFG_START_HEADING_Y: start_hy_reg <= cfg_data[15:0];
                tsg_pkg::CFG_STEP_LENGTH:     step_len_reg <= cfg_data[23:0];
                tsg_pkg::CFG_TURN_COS:        turn_cos_reg <= cfg_data[15:0];
                tsg_pkg::CFG_TURN_SIN:        turn_sin_reg <= cfg_data[15:0];
                default:                      ;   // index beyond the list: drop
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. An item moves into the compute stage whenever the
    // result register is free or is being drained this cycle.
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] sym_reg;
    logic       rst_item_reg;
    logic       go;
    logic       out_vld_reg;

    assign go       = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (go)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sym_reg      <= symbol;
            rst_item_reg <= restart;
        end
    end

    // ------------------------------------------------------------------
    // Turtle state
    // ------------------------------------------------------------------
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic signed [15:0] hx_reg, hy_reg, hx_next, hy_next;
    logic signed [16:0] prev_reg, prev_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      ptr_reg, ptr_next;

    tsg_pkg::frame_t    stack_mem [STACK_DEPTH];
    tsg_pkg::frame_t    top_reg;

    // restart reloads from the start registers before the symbol acts
    logic signed [31:0] cur_px, cur_py;
    logic signed [15:0] cur_hx, cur_hy;
    logic signed [16:0] cur_prev;
    logic [CW-1:0]      cur_cnt;
    logic [PW-1:0]      cur_ptr, pop_ptr, top_ptr;

    assign cur_px   = rst_item_reg ? start_x_reg  : pos_x_reg;
    assign cur_py   = rst_item_reg ? start_y_reg  : pos_y_reg;
    assign cur_hx   = rst_item_reg ? start_hx_reg : hx_reg;
    assign cur_hy   = rst_item_reg ? start_hy_reg : hy_reg;
    assign cur_prev = rst_item_reg ? tsg_pkg::NO_SEGMENT : prev_reg;
    assign cur_cnt  = rst_item_reg ? '0 : cnt_reg;
    assign cur_ptr  = rst_item_reg ? '0 : ptr_reg;
    assign pop_ptr  = cur_ptr - PW'(1);
    assign top_ptr  = ptr_next - PW'(1);

    logic stack_full, stack_empty, count_full;

    assign stack_full  = (cur_ptr == PW'(STACK_DEPTH));
    assign stack_empty = (cur_ptr == '0);
    assign count_full  = (cur_cnt == CW'(MAX_SEGMENTS));

    // ------------------------------------------------------------------
    // Advance: heading (Q2.14) times step (Q8.16), round half up into
    // Q16.16, add to the pen and saturate.
    // ------------------------------------------------------------------
    logic signed [24:0] len_s;
    logic signed [40:0] dx_prod, dy_prod;
    logic signed [41:0] dx_rnd, dy_rnd;
    logic signed [32:0] ex_sum, ey_sum;
    logic signed [31:0] end_x, end_y;

    assign len_s   = $signed({1'b0, step_len_reg});
    assign dx_prod = cur_hx * len_s;
    assign dy_prod = cur_hy * len_s;
    assign dx_rnd  = 42'(dx_prod) + 42'sd8192;
    assign dy_rnd  = 42'(dy_prod) + 42'sd8192;
    assign ex_sum  = 33'(cur_px) + 33'($signed(dx_rnd[41:14]));
    assign ey_sum  = 33'(cur_py) + 33'($signed(dy_rnd[41:14]));

    always_comb
    begin
        end_x = ex_sum[31:0];
        end_y = ey_sum[31:0];
        if (ex_sum[32] != ex_sum[31])
        begin
            end_x = ex_sum[32] ? tsg_pkg::POS_MIN : tsg_pkg::POS_MAX;
        end
        if (ey_sum[32] != ey_sum[31])
        begin
            end_y = ey_sum[32] ? tsg_pkg::POS_MIN : tsg_pkg::POS_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Turn: rotate the heading; minus uses +sin, plus uses -sin.
    // ------------------------------------------------------------------
    logic signed [31:0] p_xc, p_ys, p_xs, p_yc;
    logic signed [33:0] tx_sum, ty_sum;
    logic signed [34:0] tx_rnd, ty_rnd;
    logic signed [20:0] tx_q, ty_q;
    logic signed [15:0] turn_x, turn_y;
    logic               turn_minus;

    assign turn_minus = (sym_reg == tsg_pkg::SYM_MINUS);
    assign p_xc = cur_hx * turn_cos_reg;
    assign p_ys = cur_hy * turn_sin_reg;
    assign p_xs = cur_hx * turn_sin_reg;
    assign p_yc = cur_hy * turn_cos_reg;

    always_comb
    begin
        if (turn_minus)
        begin
            tx_sum = 34'(p_xc) - 34'(p_ys);
            ty_sum = 34'(p_yc) + 34'(p_xs);
        end
        else
        begin
            tx_sum = 34'(p_xc) + 34'(p_ys);
            ty_sum = 34'(p_yc) - 34'(p_xs);
        end
        tx_rnd = 35'(tx_sum) + 35'sd8192;
        ty_rnd = 35'(ty_sum) + 35'sd8192;
        tx_q   = tx_rnd[34:14];
        ty_q   = ty_rnd[34:14];
        turn_x = tx_q[15:0];
        turn_y = ty_q[15:0];
        // saturate when the upper bits are not a pure sign extension
        if (!(&tx_q[20:15] || ~|tx_q[20:15]))
        begin
            turn_x = tx_q[20] ? tsg_pkg::HEAD_MIN : tsg_pkg::HEAD_MAX;
        end
        if (!(&ty_q[20:15] || ~|ty_q[20:15]))
        begin
            turn_y = ty_q[20] ? tsg_pkg::HEAD_MIN : tsg_pkg::HEAD_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Symbol decode: next state, stack access and the result
    // ------------------------------------------------------------------
    logic [CW+16:0]     cnt_wide;
    tsg_pkg::frame_t    push_frame;
    logic               push_en;
    logic               res_en;
    tsg_pkg::status_t   res_status;
    logic signed [31:0] res_sx, res_sy, res_ex, res_ey;
    logic signed [16:0] res_parent;
    logic [15:0]        res_index;

    assign cnt_wide   = {17'b0, cur_cnt};
    assign push_frame = '{px: cur_px, py: cur_py, hx: cur_hx, hy: cur_hy,
                          prev: cur_prev};

    always_comb
    begin
        pos_x_next = cur_px;
        pos_y_next = cur_py;
        hx_next    = cur_hx;
        hy_next    = cur_hy;
        prev_next  = cur_prev;
        cnt_next   = cur_cnt;
        ptr_next   = cur_ptr;
        push_en    = 1'b0;
        res_en     = 1'b0;
        res_status = tsg_pkg::STATUS_SEGMENT;
        res_sx     = '0;
        res_sy     = '0;
        res_ex     = '0;
        res_ey     = '0;
        res_parent = '0;
        res_index  = '0;
        case (sym_reg)
            tsg_pkg::SYM_FWD:
            begin
                res_en = 1'b1;
                if (count_full)
                begin
                    res_status = tsg_pkg::STATUS_COUNT_FULL;
                end
                else
                begin
                    res_sx     = cur_px;
                    res_sy     = cur_py;
                    res_ex     = end_x;
                    res_ey     = end_y;
                    res_parent = cur_prev;
                    res_index  = cnt_wide[15:0];
                    pos_x_next = end_x;
                    pos_y_next = end_y;
                    prev_next  = $signed(cnt_wide[16:0]);
                    cnt_next   = cur_cnt + CW'(1);
                end
            end
            tsg_pkg::SYM_MINUS,
            tsg_pkg::SYM_PLUS:
            begin
                hx_next = turn_x;
                hy_next = turn_y;
            end
            tsg_pkg::SYM_OPEN:
            begin
                if (stack_full)
                begin
                    res_en     = 1'b1;
                    res_status = tsg_pkg::STATUS_STACK_FULL;
                end
                else
                begin
                    push_en  = 1'b1;
                    ptr_next = cur_ptr + PW'(1);
                end
            end
            tsg_pkg::SYM_CLOSE:
            begin
                if (stack_empty)
                begin
                    res_en     = 1'b1;
                    res_status = tsg_pkg::STATUS_STACK_EMPTY;
                end
                else
                begin
                    ptr_next   = pop_ptr;
                    pos_x_next = top_reg.px;
                    pos_y_next = top_reg.py;
                    hx_next    = top_reg.hx;
                    hy_next    = top_reg.hy;
                    prev_next  = top_reg.prev;
                end
            end
            default:
            begin
                // any other symbol leaves the turtle alone, apart from restart
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= tsg_pkg::RST_START_X;
            pos_y_reg <= tsg_pkg::RST_START_Y;
            hx_reg    <= tsg_pkg::RST_START_HEADING_X;
            hy_reg    <= tsg_pkg::RST_START_HEADING_Y;
            prev_reg  <= tsg_pkg::NO_SEGMENT;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
        end
        else if (go)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
        end
    end

    // branch stack: top_reg holds the entry just below the pointer, so a pop
    // uses it directly; refill it from the memory for the new pointer
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (push_en)
            begin
                stack_mem[cur_ptr[IW-1:0]] <= push_frame;
                top_reg                    <= push_frame;
            end
            else
            begin
                top_reg <= stack_mem[top_ptr[IW-1:0]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds while stalled; while it holds, the compute
    // stage waits and the input register fills up behind it.
    // ------------------------------------------------------------------
    tsg_pkg::status_t   status_reg;
    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [16:0] parent_reg;
    logic [15:0]        index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (go && res_en)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && res_en)
        begin
            status_reg <= res_status;
            sx_reg     <= res_sx;
            sy_reg     <= res_sy;
            ex_reg     <= res_ex;
            ey_reg     <= res_ey;
            parent_reg <= res_parent;
            index_reg  <= res_index;
        end
    end

    assign out_valid     = out_vld_reg;
    assign status        = status_reg;
    assign seg_start_x   = sx_reg;
    assign seg_start_y   = sy_reg;
    assign seg_end_x     = ex_reg;
    assign seg_end_y     = ey_reg;
    assign parent_index  = parent_reg;
    assign segment_index = index_reg;

endmodule

[rtl/tsg_checker.sv]
module tsg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [7:0]         symbol,
    input logic               restart,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [31:0] seg_start_x,
    input logic signed [31:0] seg_start_y,
    input logic signed [31:0] seg_end_x,
    input logic signed [31:0] seg_end_y,
    input logic signed [16:0] parent_index,
    input logic [15:0]        segment_index
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(seg_start_x) && $stable(seg_start_y)
            && $stable(seg_end_x) && $stable(seg_end_y)
            && $stable(parent_index) && $stable(segment_index))
        else $error("result changed while stalled");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(symbol) && $stable(restart))
        else $error("input item changed while stalled");

    // status results carry zero fields
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tsg_pkg::STATUS_SEGMENT) |->
            seg_start_x == 0 && seg_start_y == 0 && seg_end_x == 0
            && seg_end_y == 0 && parent_index == 0 && segment_index == 0)
        else $error("status result with nonzero fields");

    // reset drops any held result
    a_reset_clear: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind turtle_segment_generator_top tsg_checker u_tsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .symbol        (symbol),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .seg_start_x   (seg_start_x),
    .seg_start_y   (seg_start_y),
    .seg_end_x     (seg_end_x),
    .seg_end_y     (seg_end_y),
    .parent_index  (parent_index),
    .segment_index (segment_index)
);
